// ===== sv/srec_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, types and character helpers for the s1 record encoder
package srec_pkg;

	localparam int unsigned REC_BYTES  = 16;
	localparam int unsigned FILL_W     = 5;
	localparam int unsigned PTR_W      = 4;
	localparam int unsigned ADDR_W     = 16;

	localparam logic [FILL_W-1:0] FILL_FULL    = FILL_W'(REC_BYTES);
	localparam logic [7:0]        REC_OVERHEAD = 8'd3;

	localparam logic [3:0] HDR_LAST   = 4'd7;
	localparam logic [3:0] CSUM_LAST  = 4'd2;
	localparam logic [3:0] TRAIL_LAST = 4'd10;

	localparam logic [7:0] CHAR_S  = 8'h53;
	localparam logic [7:0] CHAR_1  = 8'h31;
	localparam logic [7:0] CHAR_NL = 8'h0a;

	localparam logic ACT_DATA = 1'b0;
	localparam logic ACT_END  = 1'b1;

	typedef struct packed {
		logic             we;
		logic [PTR_W-1:0] waddr;
		logic [7:0]       wdata;
		logic             re;
		logic [PTR_W-1:0] raddr;
	} mem_req_t;

	typedef struct packed {
		logic              busy;
		logic [FILL_W-1:0] fill;
	} seq_status_t;

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		logic [7:0] c;
		if (n < 4'd10) begin
			c = 8'h30 + {4'h0, n};
		end else begin
			c = 8'h57 + {4'h0, n};
		end
		return c;
	endfunction

	// terminator line "S9030000FC\n"
	function automatic logic [7:0] trailer_char(input logic [3:0] i);
		logic [7:0] c;
		case (i)
			4'd0:    c = 8'h53;
			4'd1:    c = 8'h39;
			4'd2:    c = 8'h30;
			4'd3:    c = 8'h33;
			4'd4:    c = 8'h30;
			4'd5:    c = 8'h30;
			4'd6:    c = 8'h30;
			4'd7:    c = 8'h30;
			4'd8:    c = 8'h46;
			4'd9:    c = 8'h43;
			4'd10:   c = 8'h0a;
			default: c = 8'h0a;
		endcase
		return c;
	endfunction

endpackage

// ===== sv/srec_if.sv =====
`timescale 1ns / 1ps
// channel interfaces: input items, output characters, configuration writes
interface srec_in_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] data_byte;
	modport source (output valid, output action, output data_byte, input ready);
	modport sink (input valid, input action, input data_byte, output ready);
endinterface

interface srec_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       last_char;
	modport source (output valid, output out_char, output last_char, input ready);
	modport sink (input valid, input out_char, input last_char, output ready);
endinterface

interface srec_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] start_address;
	modport source (output valid, output start_address, input ready);
	modport sink (input valid, input start_address, output ready);
endinterface

// ===== sv/srec_mem.sv =====
`timescale 1ns / 1ps
// record buffer: 16 x 8 synchronous ram, one write and one registered read port
module srec_mem (
	input  logic              clk,
	input  srec_pkg::mem_req_t req,
	output logic [7:0]        rd_data
);
	import srec_pkg::*;

	logic [7:0] mem_q [REC_BYTES];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rd_data <= mem_q[req.raddr];
		end
	end

endmodule

// ===== sv/srec_seq.sv =====
`timescale 1ns / 1ps
// record sequencer: buffer fill, address and checksum, character generation
module srec_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	srec_in_if.sink               din,
	srec_out_if.source            dout,
	srec_cfg_if.sink              cfg,
	output srec_pkg::mem_req_t    mem_req,
	input  logic [7:0]            rd_data,
	output srec_pkg::seq_status_t status
);
	import srec_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_HDR   = 5'b00010,
		S_DATA  = 5'b00100,
		S_CSUM  = 5'b01000,
		S_TRAIL = 5'b10000
	} state_t;

	state_t            state_q;
	logic [FILL_W-1:0] fill_q;
	logic [ADDR_W-1:0] addr_q;
	logic [ADDR_W-1:0] start_q;
	logic              active_q;
	logic              end_q;
	logic [3:0]        idx_q;
	logic [PTR_W-1:0]  ptr_q;
	logic [7:0]        sum_q;
	logic              out_valid_q;
	logic [7:0]        out_char_q;
	logic              out_last_q;

	logic              in_acc;
	logic              fire;
	logic [7:0]        count_c;
	logic [7:0]        byte_c;
	logic [7:0]        char_c;
	logic              last_c;
	logic [FILL_W-1:0] ptr_inc;
	logic              more_data;

	assign in_acc    = din.valid && din.ready;
	assign fire      = (state_q != S_IDLE) && (!out_valid_q || dout.ready);
	assign count_c   = 8'(fill_q) + REC_OVERHEAD;
	assign ptr_inc   = {1'b0, ptr_q} + FILL_W'(1);
	assign more_data = (ptr_inc != fill_q);

	assign din.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;

	assign dout.valid     = out_valid_q;
	assign dout.out_char  = out_char_q;
	assign dout.last_char = out_last_q;

	assign status.busy = (state_q != S_IDLE);
	assign status.fill = fill_q;

	// header bytes: count, address high, address low; otherwise the inverted checksum
	always_comb begin
		case (idx_q[2:1])
			2'd1:    byte_c = count_c;
			2'd2:    byte_c = addr_q[15:8];
			2'd3:    byte_c = addr_q[7:0];
			default: byte_c = ~sum_q;
		endcase
	end

	always_comb begin
		char_c = CHAR_NL;
		last_c = 1'b0;
		case (state_q)
			S_HDR: begin
				if (idx_q[2:1] == 2'd0) begin
					char_c = idx_q[0] ? CHAR_1 : CHAR_S;
				end else begin
					char_c = hex_char(idx_q[0] ? byte_c[3:0] : byte_c[7:4]);
				end
			end
			S_DATA: begin
				char_c = hex_char(idx_q[0] ? rd_data[3:0] : rd_data[7:4]);
			end
			S_CSUM: begin
				if (idx_q == CSUM_LAST) begin
					char_c = CHAR_NL;
					last_c = !end_q;
				end else begin
					char_c = hex_char(idx_q[0] ? ~sum_q[3:0] : ~sum_q[7:4]);
				end
			end
			S_TRAIL: begin
				char_c = trailer_char(idx_q);
				last_c = (idx_q == TRAIL_LAST);
			end
			default: begin
				char_c = CHAR_NL;
				last_c = 1'b0;
			end
		endcase
	end

	always_comb begin
		mem_req.we    = in_acc && (din.action == ACT_DATA);
		mem_req.waddr = fill_q[PTR_W-1:0];
		mem_req.wdata = din.data_byte;
		mem_req.re    = 1'b0;
		mem_req.raddr = ptr_inc[PTR_W-1:0];
		if (fire && (state_q == S_HDR) && (idx_q == HDR_LAST)) begin
			mem_req.re    = 1'b1;
			mem_req.raddr = '0;
		end else if (fire && (state_q == S_DATA) && idx_q[0] && more_data) begin
			mem_req.re = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			addr_q      <= '0;
			start_q     <= '0;
			active_q    <= 1'b0;
			end_q       <= 1'b0;
			idx_q       <= '0;
			ptr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				start_q <= cfg.start_address;
				if (!active_q) begin
					addr_q <= cfg.start_address;
				end
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (dout.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						idx_q <= '0;
						if (din.action == ACT_DATA) begin
							fill_q   <= fill_q + FILL_W'(1);
							active_q <= 1'b1;
							end_q    <= 1'b0;
							if (fill_q == FILL_FULL - FILL_W'(1)) begin
								state_q <= S_HDR;
							end
						end else begin
							end_q   <= 1'b1;
							state_q <= (fill_q != '0) ? S_HDR : S_TRAIL;
						end
					end
				end
				S_HDR: begin
					if (fire) begin
						idx_q <= idx_q + 4'd1;
						if (idx_q == HDR_LAST) begin
							state_q <= S_DATA;
							idx_q   <= '0;
							ptr_q   <= '0;
						end
					end
				end
				S_DATA: begin
					if (fire) begin
						idx_q <= idx_q + 4'd1;
						if (idx_q[0]) begin
							idx_q <= '0;
							if (more_data) begin
								ptr_q <= ptr_inc[PTR_W-1:0];
							end else begin
								state_q <= S_CSUM;
							end
						end
					end
				end
				S_CSUM: begin
					if (fire) begin
						idx_q <= idx_q + 4'd1;
						if (idx_q == CSUM_LAST) begin
							idx_q   <= '0;
							addr_q  <= addr_q + ADDR_W'(fill_q);
							fill_q  <= '0;
							state_q <= end_q ? S_TRAIL : S_IDLE;
						end
					end
				end
				S_TRAIL: begin
					if (fire) begin
						idx_q <= idx_q + 4'd1;
						if (idx_q == TRAIL_LAST) begin
							idx_q    <= '0;
							addr_q   <= start_q;
							fill_q   <= '0;
							active_q <= 1'b0;
							state_q  <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// running checksum: header bytes on the first header character, then each data byte
	always_ff @(posedge clk) begin
		if (fire && (state_q == S_HDR) && (idx_q == '0)) begin
			sum_q <= count_c + addr_q[15:8] + addr_q[7:0];
		end else if (fire && (state_q == S_DATA) && idx_q[0]) begin
			sum_q <= sum_q + rd_data;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_char_q <= char_c;
			out_last_q <= last_c;
		end
	end

endmodule

// ===== sv/srecord_s1_encoder_top.sv =====
`timescale 1ns / 1ps
// top level of the motorola s1 record encoder
// a data byte that does not complete a record is buffered and input stays ready
// an item that completes a record holds off input until that record has been sent
// an end item also sends the terminator; one character per ready cycle from the output register
// state leaves idle, then the first character is registered; output stalls freeze the sequencer
// async reset clears control state and sets the address and start address to zero
module srecord_s1_encoder_top (
	input  logic       clk,
	input  logic       arst_n,
	srec_in_if.sink    din,
	srec_out_if.source dout,
	srec_cfg_if.sink   cfg
);
	import srec_pkg::*;

	mem_req_t    mem_req;
	logic [7:0]  rd_data;
	seq_status_t status;

	srec_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.din     (din),
		.dout    (dout),
		.cfg     (cfg),
		.mem_req (mem_req),
		.rd_data (rd_data),
		.status  (status)
	);

	srec_mem u_mem (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (rd_data)
	);

`ifndef NO_ASSERTIONS
	a_no_rw_overlap : assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_req.we && mem_req.re))
		else $error("buffer read and write in the same cycle");

	a_fill_bound : assert property (@(posedge clk) disable iff (!arst_n)
		status.fill <= FILL_FULL)
		else $error("fill count beyond record size");

	a_write_on_data : assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.we |-> (din.valid && din.ready && din.action == ACT_DATA))
		else $error("buffer write without a data item");

	a_end_busy : assert property (@(posedge clk) disable iff (!arst_n)
		(din.valid && din.ready && din.action == ACT_END) |=> (status.busy && !din.ready))
		else $error("end item did not start the terminator");
`endif

endmodule

// ===== dv/tb_srecord_s1_encoder_top.sv =====
`timescale 1ns / 1ps
// self-checking testbench of the s1 record encoder with random stalls on both sides
module tb_srecord_s1_encoder_top;
	import srec_pkg::*;

	localparam int ITEMS          = 260;
	localparam int SETTLE_CYCLES  = 4;
	localparam int DRAIN_CYCLES   = 20;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 3000;

	// keeps the encoder state on the testbench side and the characters it should emit
	class srec_scoreboard;
		typedef struct {
			logic [7:0] ch;
			logic       last;
		} char_t;

		logic [7:0]  rec_bytes [16];
		logic [4:0]  fill_cnt;
		logic [15:0] rec_addr;
		logic [15:0] start_addr;
		bit          active;
		char_t       char_q [$];
		int          errors;
		int          records;
		int          chars_checked;

		function new();
			fill_cnt      = '0;
			rec_addr      = '0;
			start_addr    = '0;
			active        = 1'b0;
			errors        = 0;
			records       = 0;
			chars_checked = 0;
		endfunction

		function void put_char(logic [7:0] c);
			char_t e;
			e.ch   = c;
			e.last = 1'b0;
			char_q.push_back(e);
		endfunction

		function logic [7:0] nibble_char(logic [3:0] nib);
			logic [7:0] c;
			if (nib < 4'd10) begin
				c = 8'h30 + 8'(nib);
			end else begin
				c = 8'h61 + 8'(nib) - 8'd10;
			end
			return c;
		endfunction

		function void put_hex(logic [7:0] v);
			put_char(nibble_char(v[7:4]));
			put_char(nibble_char(v[3:0]));
		endfunction

		function void emit_record();
			logic [7:0] cnt;
			logic [7:0] sum;
			cnt = 8'(fill_cnt) + 8'd3;
			sum = cnt + rec_addr[15:8] + rec_addr[7:0];
			put_char("S");
			put_char("1");
			put_hex(cnt);
			put_hex(rec_addr[15:8]);
			put_hex(rec_addr[7:0]);
			for (int i = 0; i < int'(fill_cnt); i++) begin
				put_hex(rec_bytes[i]);
				sum = sum + rec_bytes[i];
			end
			put_hex(~sum);
			put_char(8'h0a);
			rec_addr = rec_addr + 16'(fill_cnt);
			fill_cnt = '0;
			records++;
		endfunction

		function void note_input(logic act, logic [7:0] b);
			string term;
			int    n0;
			term = "S9030000FC";
			n0   = char_q.size();
			if (act != ACT_END) begin
				active              = 1'b1;
				rec_bytes[fill_cnt[3:0]] = b;
				fill_cnt            = fill_cnt + 5'd1;
				if (fill_cnt >= 5'd16) begin
					emit_record();
				end
			end else begin
				if (fill_cnt != 0) begin
					emit_record();
				end
				for (int i = 0; i < term.len(); i++) begin
					put_char(term[i]);
				end
				put_char(8'h0a);
				rec_addr = start_addr;
				fill_cnt = '0;
				active   = 1'b0;
			end
			if (char_q.size() > n0) begin
				char_q[char_q.size() - 1].last = 1'b1;
			end
		endfunction

		// a new start address applies at once only when no stream is open
		function void note_start(logic [15:0] a);
			start_addr = a;
			if (!active) begin
				rec_addr = a;
			end
		endfunction

		function void check_char(logic [7:0] c, logic l);
			char_t e;
			if (char_q.size() == 0) begin
				$error("unexpected character %h (last_char %b) with nothing pending", c, l);
				errors++;
			end else begin
				e = char_q.pop_front();
				if (c !== e.ch) begin
					$error("out_char mismatch: expected %h, got %h", e.ch, c);
					errors++;
				end
				if (l !== e.last) begin
					$error("last_char mismatch: expected %b, got %b", e.last, l);
					errors++;
				end
			end
			chars_checked++;
		endfunction

		function int pending();
			return char_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	srec_in_if  din ();
	srec_out_if dout ();
	srec_cfg_if cfg ();

	srecord_s1_encoder_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din.sink),
		.dout   (dout.source),
		.cfg    (cfg.sink)
	);

	srec_scoreboard sb = new();

	int src_max;
	int snk_max;
	int snk_gap;
	int snk_hold;
	int idle_cycles;
	int n_items;
	int n_ends;
	int n_cfg;

	initial begin
		clk = 1'b0;
	end

	always #10 clk = ~clk;

	// output side: ready drops for a drawn number of cycles after each character, or for a requested long hold
	always @(negedge clk) begin
		if (snk_hold > 0) begin
			snk_gap  = snk_hold;
			snk_hold = 0;
		end
		if (snk_gap > 0) begin
			dout.ready <= 1'b0;
			snk_gap--;
		end else begin
			dout.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && dout.valid && dout.ready) begin
			sb.check_char(dout.out_char, dout.last_char);
			snk_gap = (snk_max == 0) ? 0 : $urandom_range(0, snk_max);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((din.valid && din.ready) || (dout.valid && dout.ready) ||
			    (cfg.valid && cfg.ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
				$display("Verification failed");
				$finish;
			end
		end
	end

	// all tasks start and end on a falling edge
	task automatic send_item(input logic act, input logic [7:0] b);
		int gap;
		gap = (src_max == 0) ? 0 : $urandom_range(0, src_max);
		if (gap > 0) begin
			din.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		din.valid     <= 1'b1;
		din.action    <= act;
		din.data_byte <= b;
		do @(posedge clk); while (!din.ready);
		sb.note_input(act, b);
		n_items++;
		if (act == ACT_END) begin
			n_ends++;
		end
		@(negedge clk);
	endtask

	task automatic wait_idle();
		din.valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_start(input logic [15:0] addr);
		wait_idle();
		cfg.valid         <= 1'b1;
		cfg.start_address <= addr;
		do @(posedge clk); while (!cfg.ready);
		sb.note_start(addr);
		n_cfg++;
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	function automatic logic [15:0] pick_addr();
		logic [15:0] a;
		case ($urandom_range(0, 3))
			0:       a = 16'h0000;
			1:       a = 16'hffff;
			default: a = 16'($urandom_range(0, 65535));
		endcase
		return a;
	endfunction

	function automatic int pick_idle();
		int m;
		case ($urandom_range(0, 3))
			0:       m = 0;
			1:       m = 4;
			default: m = 19;
		endcase
		return m;
	endfunction

	initial begin
		logic [7:0] dir_bytes [16];
		int         len;
		int         mid;
		int         phase;

		dir_bytes = '{8'h00, 8'hff, 8'h01, 8'hfe, 8'h80, 8'h7f, 8'h55, 8'haa,
		              8'h10, 8'hef, 8'h0f, 8'hf0, 8'h5a, 8'ha5, 8'hc3, 8'h3c};
		arst_n            = 1'b0;
		din.valid         = 1'b0;
		din.action        = ACT_DATA;
		din.data_byte     = 8'h00;
		cfg.valid         = 1'b0;
		cfg.start_address = 16'h0000;
		dout.ready        = 1'b0;
		src_max           = 0;
		snk_max           = 0;
		snk_gap           = 0;
		snk_hold          = 0;
		idle_cycles       = 0;
		n_items           = 0;
		n_ends            = 0;
		n_cfg             = 0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty end, full record wrapping the address, partial record,
		// start address change inside an open stream, back to back ends
		write_start(16'hfff8);
		send_item(ACT_END, 8'hff);
		foreach (dir_bytes[i]) begin
			send_item(ACT_DATA, dir_bytes[i]);
		end
		send_item(ACT_DATA, 8'hff);
		send_item(ACT_DATA, 8'h00);
		send_item(ACT_DATA, 8'h9e);
		write_start(16'hffff);
		send_item(ACT_END, 8'h00);
		send_item(ACT_END, 8'h5a);
		src_max = 19;
		snk_max = 19;
		send_item(ACT_DATA, 8'hc7);
		send_item(ACT_END, 8'h81);

		phase = 0;
		while (n_items < ITEMS) begin
			src_max = pick_idle();
			snk_max = pick_idle();
			case ($urandom_range(0, 7))
				0:       len = 0;
				1:       len = 16;
				2:       len = 32;
				3:       len = $urandom_range(1, 3);
				default: len = $urandom_range(0, 40);
			endcase
			if (phase == 0) begin
				write_start(16'h0000);
			end else if ($urandom_range(0, 2) == 0) begin
				write_start(pick_addr());
			end
			if (phase == 1) begin
				// output stalls long while input keeps coming until it backs up
				src_max  = 0;
				len      = 48;
				snk_hold = HOLD_CYCLES;
			end
			mid = ($urandom_range(0, 3) == 0) ? $urandom_range(0, len) : -1;
			for (int i = 0; i < len; i++) begin
				if (i == mid) begin
					write_start(pick_addr());
				end
				send_item(ACT_DATA, 8'($urandom_range(0, 255)));
			end
			send_item(ACT_END, 8'($urandom_range(0, 255)));
			if ($urandom_range(0, 5) == 0) begin
				send_item(ACT_END, 8'($urandom_range(0, 255)));
			end
			phase++;
		end

		din.valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("covered %0d input items including %0d ends and %0d start address writes",
		         n_items, n_ends, n_cfg);
		$display("checked %0d characters forming %0d data records", sb.chars_checked,
		         sb.records);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/srec_pkg.sv
sv/srec_if.sv
sv/srec_mem.sv
sv/srec_seq.sv
sv/srecord_s1_encoder_top.sv
dv/tb_srecord_s1_encoder_top.sv
